// ===== rtl/rcc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcc_pkg - shared types for the rectangle/circle collision pipeline
// Names the four rectangle sides whose axis distances to the centre are
// carried through the pipeline stages.
// ----------------------------------------------------------------------------
package rcc_pkg;

   localparam int NUM_SIDES = 4;

   typedef enum logic [1:0] {
      SIDE_LEFT   = 2'd0,
      SIDE_RIGHT  = 2'd1,
      SIDE_TOP    = 2'd2,
      SIDE_BOTTOM = 2'd3
   } side_type;

endpackage
`default_nettype wire

// ===== rtl/rect_circle_collision.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rect_circle_collision - rectangle versus circle hit test with contact point
// Fully pipelined; one word in and one word out per clock while rsp_tready allows.
// ----------------------------------------------------------------------------
// Takes one query word per clock while the output is not stalled, and
// returns one result word per query, in order. There are four register
// stages: two of edge differences and overlap clipping, one squaring stage
// and one corner-compare stage that is also the output register, which
// drives rsp_tvalid. While a result waits on rsp_tready the whole pipeline
// holds. Ready on the input comes from a one-word skid register, so the
// input side never waits on the output side combinationally: a word taken
// during a stall sits in the skid register and req_tready drops from the
// next cycle, and once the pipeline moves again req_tready stays low until
// the skid word has entered. Coordinates are signed fixed point; the
// fraction position does not matter to the logic. A query with no hit
// returns a zero contact point.
module rect_circle_collision #(
   parameter int COORD_WIDTH = 20
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // rect_left, rect_top, rect_right, rect_bottom, circle_x, circle_y,
   // circle_radius (COORD_WIDTH-1 bits), zero padding
   input  logic [((7*COORD_WIDTH+6)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // hit, point_x, point_y, zero padding
   output logic [((2*COORD_WIDTH+8)/8)*8-1:0] rsp_tdata
);
   import rcc_pkg::*;

   localparam int W      = COORD_WIDTH;
   localparam int IN_W   = ((7*W+6)/8)*8;
   localparam int OUT_W  = ((2*W+8)/8)*8;

   logic              advance;
   logic              s0_valid;
   logic [IN_W-1:0]   s0_data;

   logic                          sp_valid, sp_band, sp_bhit;
   logic [NUM_SIDES-1:0]          sp_near;
   logic [NUM_SIDES-1:0][W-2:0]   sp_dist;
   logic signed [W:0]             sp_ol, sp_or, sp_ot, sp_ob;
   logic [W-2:0]                  sp_rad;

   logic                          sq_valid, sq_band, sq_bhit;
   logic [NUM_SIDES-1:0]          sq_near;
   logic [NUM_SIDES-1:0][2*W-3:0] sq_dist;
   logic [2*W-3:0]                sq_rad;
   logic [W-1:0]                  sq_mx, sq_my;

   logic                          hit;
   logic [W-1:0]                  point_x, point_y;

   rcc_skid #(.DATA_W(IN_W)) u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .advance   (advance),
      .out_valid (s0_valid),
      .out_data  (s0_data)
   );

   rcc_span #(.W(W)) u_span (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_valid      (s0_valid),
      .rect_left     (signed'(s0_data[W-1:0])),
      .rect_top      (signed'(s0_data[2*W-1:W])),
      .rect_right    (signed'(s0_data[3*W-1:2*W])),
      .rect_bottom   (signed'(s0_data[4*W-1:3*W])),
      .circle_x      (signed'(s0_data[5*W-1:4*W])),
      .circle_y      (signed'(s0_data[6*W-1:5*W])),
      .circle_radius (s0_data[7*W-2:6*W]),
      .out_valid     (sp_valid),
      .band          (sp_band),
      .band_hit      (sp_bhit),
      .near          (sp_near),
      .side_dist     (sp_dist),
      .ov_left       (sp_ol),
      .ov_right      (sp_or),
      .ov_top        (sp_ot),
      .ov_bottom     (sp_ob),
      .radius        (sp_rad)
   );

   rcc_square #(.W(W)) u_square (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (sp_valid),
      .band         (sp_band),
      .band_hit     (sp_bhit),
      .near         (sp_near),
      .side_dist    (sp_dist),
      .ov_left      (sp_ol),
      .ov_right     (sp_or),
      .ov_top       (sp_ot),
      .ov_bottom    (sp_ob),
      .radius       (sp_rad),
      .out_valid    (sq_valid),
      .band_out     (sq_band),
      .band_hit_out (sq_bhit),
      .near_out     (sq_near),
      .dist_sq      (sq_dist),
      .radius_sq    (sq_rad),
      .mid_x        (sq_mx),
      .mid_y        (sq_my)
   );

   rcc_resolve #(.W(W)) u_resolve (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sq_valid),
      .band      (sq_band),
      .band_hit  (sq_bhit),
      .near      (sq_near),
      .dist_sq   (sq_dist),
      .radius_sq (sq_rad),
      .mid_x     (sq_mx),
      .mid_y     (sq_my),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .hit       (hit),
      .point_x   (point_x),
      .point_y   (point_y)
   );

   assign rsp_tdata = OUT_W'({point_y, point_x, hit});

endmodule
`default_nettype wire

// ===== rtl/rcc_skid.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcc_skid - input skid stage
// Holds one word taken while the pipeline is stalled, so that the input
// ready comes straight from a register.
// ----------------------------------------------------------------------------
module rcc_skid #(
   parameter int DATA_W = 144
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [DATA_W-1:0] in_data,
   input  logic              advance,
   output logic              out_valid,
   output logic [DATA_W-1:0] out_data
);

   logic              skid_valid_ff, skid_valid_in;
   logic [DATA_W-1:0] skid_data_ff;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = skid_valid_ff || (in_valid && in_ready);
   assign out_data  = skid_valid_ff ? skid_data_ff : in_data;

   always_comb begin
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff && advance) begin
         skid_valid_in = 1'b0;
      end else if (!skid_valid_ff && in_valid && !advance) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_valid_ff && in_valid && !advance) begin
         skid_data_ff <= in_data;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/rcc_span.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcc_span - edge differences, band tests and overlap bounds
// Two stages: differences and grown-rectangle compares, then absolute axis
// distances, near flags and the clipped overlap of rectangle and circle box.
// ----------------------------------------------------------------------------
module rcc_span #(
   parameter int W = 20
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    advance,
   input  logic                                    in_valid,
   input  logic signed [W-1:0]                     rect_left,
   input  logic signed [W-1:0]                     rect_top,
   input  logic signed [W-1:0]                     rect_right,
   input  logic signed [W-1:0]                     rect_bottom,
   input  logic signed [W-1:0]                     circle_x,
   input  logic signed [W-1:0]                     circle_y,
   input  logic        [W-2:0]                     circle_radius,
   output logic                                    out_valid,
   output logic                                    band,
   output logic                                    band_hit,
   output logic        [rcc_pkg::NUM_SIDES-1:0]    near,
   output logic        [rcc_pkg::NUM_SIDES-1:0][W-2:0] side_dist,
   output logic signed [W:0]                       ov_left,
   output logic signed [W:0]                       ov_right,
   output logic signed [W:0]                       ov_top,
   output logic signed [W:0]                       ov_bottom,
   output logic        [W-2:0]                     radius
);
   import rcc_pkg::*;

   // stage one
   logic signed [W:0] lw, tw, rw, bw, cxw, cyw, radw;
   logic              v1_ff;
   logic              band1_ff, band1_in;
   logic              bhit1_ff, bhit1_in;
   logic signed [W:0] diff1_ff [NUM_SIDES];
   logic signed [W:0] diff1_in [NUM_SIDES];
   logic signed [W:0] cxm1_ff, cxp1_ff, cym1_ff, cyp1_ff;
   logic signed [W-1:0] l1_ff, r1_ff, t1_ff, b1_ff;
   logic        [W-2:0] rad1_ff;

   // stage two
   logic        [W:0] mag [NUM_SIDES];
   logic signed [W:0] l1w, r1w, t1w, b1w;
   logic              v2_ff;
   logic              band2_ff, bhit2_ff;
   logic [NUM_SIDES-1:0]        near2_ff, near2_in;
   logic [NUM_SIDES-1:0][W-2:0] dist2_ff, dist2_in;
   logic signed [W:0] ol2_ff, ol2_in, or2_ff, or2_in;
   logic signed [W:0] ot2_ff, ot2_in, ob2_ff, ob2_in;
   logic        [W-2:0] rad2_ff;

   assign lw   = {rect_left[W-1], rect_left};
   assign tw   = {rect_top[W-1], rect_top};
   assign rw   = {rect_right[W-1], rect_right};
   assign bw   = {rect_bottom[W-1], rect_bottom};
   assign cxw  = {circle_x[W-1], circle_x};
   assign cyw  = {circle_y[W-1], circle_y};
   assign radw = signed'({2'b00, circle_radius});

   always_comb begin
      band1_in = ((rect_left <= circle_x) && (circle_x <= rect_right)) ||
                 ((rect_top <= circle_y) && (circle_y <= rect_bottom));
      bhit1_in = !((cxw < lw - radw) || (cxw > rw + radw) ||
                   (cyw < tw - radw) || (cyw > bw + radw));
      diff1_in[SIDE_LEFT]   = lw - cxw;
      diff1_in[SIDE_RIGHT]  = rw - cxw;
      diff1_in[SIDE_TOP]    = tw - cyw;
      diff1_in[SIDE_BOTTOM] = bw - cyw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         band1_ff <= band1_in;
         bhit1_ff <= bhit1_in;
         for (int i = 0; i < NUM_SIDES; i++) begin
            diff1_ff[i] <= diff1_in[i];
         end
         cxm1_ff <= cxw - radw;
         cxp1_ff <= cxw + radw;
         cym1_ff <= cyw - radw;
         cyp1_ff <= cyw + radw;
         l1_ff   <= rect_left;
         r1_ff   <= rect_right;
         t1_ff   <= rect_top;
         b1_ff   <= rect_bottom;
         rad1_ff <= circle_radius;
      end
   end

   assign l1w = {l1_ff[W-1], l1_ff};
   assign r1w = {r1_ff[W-1], r1_ff};
   assign t1w = {t1_ff[W-1], t1_ff};
   assign b1w = {b1_ff[W-1], b1_ff};

   always_comb begin
      for (int i = 0; i < NUM_SIDES; i++) begin
         mag[i]      = diff1_ff[i][W] ? (W+1)'(-diff1_ff[i]) : diff1_ff[i];
         near2_in[i] = mag[i] < {2'b00, rad1_ff};
         dist2_in[i] = mag[i][W-2:0];
      end
      ol2_in = (l1w > cxm1_ff) ? l1w : cxm1_ff;
      or2_in = (r1w < cxp1_ff) ? r1w : cxp1_ff;
      ot2_in = (t1w > cym1_ff) ? t1w : cym1_ff;
      ob2_in = (b1w < cyp1_ff) ? b1w : cyp1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         band2_ff <= band1_ff;
         bhit2_ff <= bhit1_ff;
         near2_ff <= near2_in;
         dist2_ff <= dist2_in;
         ol2_ff   <= ol2_in;
         or2_ff   <= or2_in;
         ot2_ff   <= ot2_in;
         ob2_ff   <= ob2_in;
         rad2_ff  <= rad1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign band      = band2_ff;
   assign band_hit  = bhit2_ff;
   assign near      = near2_ff;
   assign side_dist = dist2_ff;
   assign ov_left   = ol2_ff;
   assign ov_right  = or2_ff;
   assign ov_top    = ot2_ff;
   assign ov_bottom = ob2_ff;
   assign radius    = rad2_ff;

endmodule
`default_nettype wire

// ===== rtl/rcc_square.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcc_square - squaring stage
// Squares the four axis distances and the radius, and forms the floored
// overlap midpoints.
// ----------------------------------------------------------------------------
module rcc_square #(
   parameter int W = 20
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        advance,
   input  logic                                        in_valid,
   input  logic                                        band,
   input  logic                                        band_hit,
   input  logic        [rcc_pkg::NUM_SIDES-1:0]        near,
   input  logic        [rcc_pkg::NUM_SIDES-1:0][W-2:0] side_dist,
   input  logic signed [W:0]                           ov_left,
   input  logic signed [W:0]                           ov_right,
   input  logic signed [W:0]                           ov_top,
   input  logic signed [W:0]                           ov_bottom,
   input  logic        [W-2:0]                         radius,
   output logic                                        out_valid,
   output logic                                        band_out,
   output logic                                        band_hit_out,
   output logic        [rcc_pkg::NUM_SIDES-1:0]        near_out,
   output logic        [rcc_pkg::NUM_SIDES-1:0][2*W-3:0] dist_sq,
   output logic        [2*W-3:0]                       radius_sq,
   output logic        [W-1:0]                         mid_x,
   output logic        [W-1:0]                         mid_y
);
   import rcc_pkg::*;

   logic                               v_ff;
   logic                               band_ff, bhit_ff;
   logic [NUM_SIDES-1:0]               near_ff;
   logic [NUM_SIDES-1:0][2*W-3:0]      sq_ff, sq_in;
   logic [2*W-3:0]                     rsq_ff, rsq_in;
   logic signed [W+1:0]                sum_x, sum_y;
   logic [W-1:0]                       mx_ff, my_ff;

   always_comb begin
      for (int i = 0; i < NUM_SIDES; i++) begin
         sq_in[i] = (2*W-2)'(side_dist[i]) * (2*W-2)'(side_dist[i]);
      end
      rsq_in = (2*W-2)'(radius) * (2*W-2)'(radius);
      sum_x  = {ov_left[W], ov_left} + {ov_right[W], ov_right};
      sum_y  = {ov_top[W], ov_top} + {ov_bottom[W], ov_bottom};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (advance) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         band_ff <= band;
         bhit_ff <= band_hit;
         near_ff <= near;
         sq_ff   <= sq_in;
         rsq_ff  <= rsq_in;
         mx_ff   <= sum_x[W:1];
         my_ff   <= sum_y[W:1];
      end
   end

   assign out_valid    = v_ff;
   assign band_out     = band_ff;
   assign band_hit_out = bhit_ff;
   assign near_out     = near_ff;
   assign dist_sq      = sq_ff;
   assign radius_sq    = rsq_ff;
   assign mid_x        = mx_ff;
   assign mid_y        = my_ff;

endmodule
`default_nettype wire

// ===== rtl/rcc_resolve.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcc_resolve - corner test and output register
// Compares each corner's squared distance with the squared radius, picks
// the band or corner verdict and holds the result word for the consumer.
// ----------------------------------------------------------------------------
module rcc_resolve #(
   parameter int W = 20
) (
   input  logic                                          clock,
   input  logic                                          reset,
   output logic                                          advance,
   input  logic                                          in_valid,
   input  logic                                          band,
   input  logic                                          band_hit,
   input  logic [rcc_pkg::NUM_SIDES-1:0]                 near,
   input  logic [rcc_pkg::NUM_SIDES-1:0][2*W-3:0]        dist_sq,
   input  logic [2*W-3:0]                                radius_sq,
   input  logic [W-1:0]                                  mid_x,
   input  logic [W-1:0]                                  mid_y,
   output logic                                          out_valid,
   input  logic                                          out_ready,
   output logic                                          hit,
   output logic [W-1:0]                                  point_x,
   output logic [W-1:0]                                  point_y
);
   import rcc_pkg::*;

   logic           valid_ff;
   logic           hit_ff, hit_in;
   logic [W-1:0]   px_ff, py_ff;
   logic [3:0]     corner;

   function automatic logic corner_in(input logic a_near, input logic b_near,
                                      input logic [2*W-3:0] a_sq,
                                      input logic [2*W-3:0] b_sq,
                                      input logic [2*W-3:0] r_sq);
      logic [2*W-2:0] s;
      s = {1'b0, a_sq} + {1'b0, b_sq};
      return a_near && b_near && (s < {1'b0, r_sq});
   endfunction

   assign advance = !valid_ff || out_ready;

   always_comb begin
      corner[0] = corner_in(near[SIDE_LEFT], near[SIDE_TOP],
                            dist_sq[SIDE_LEFT], dist_sq[SIDE_TOP], radius_sq);
      corner[1] = corner_in(near[SIDE_LEFT], near[SIDE_BOTTOM],
                            dist_sq[SIDE_LEFT], dist_sq[SIDE_BOTTOM], radius_sq);
      corner[2] = corner_in(near[SIDE_RIGHT], near[SIDE_TOP],
                            dist_sq[SIDE_RIGHT], dist_sq[SIDE_TOP], radius_sq);
      corner[3] = corner_in(near[SIDE_RIGHT], near[SIDE_BOTTOM],
                            dist_sq[SIDE_RIGHT], dist_sq[SIDE_BOTTOM], radius_sq);
      hit_in = band ? band_hit : (|corner);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hit_ff <= hit_in;
         px_ff  <= hit_in ? mid_x : '0;
         py_ff  <= hit_in ? mid_y : '0;
      end
   end

   assign out_valid = valid_ff;
   assign hit       = hit_ff;
   assign point_x   = px_ff;
   assign point_y   = py_ff;

endmodule
`default_nettype wire
